// ===== hdl/dfwd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfwd_pkg
// shared types, constants and helpers for the deauth flood window detector
// ----------------------------------------------------------------------------
package dfwd_pkg;

    localparam int NUM_CHANNELS = 11;
    localparam int COUNT_WIDTH  = 16;
    localparam int CHAN_WIDTH   = 4;
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
    localparam logic [7:0]  MGMT_MIN      = 8'h80;
    localparam logic [7:0]  SUBTYPE_MASK  = 8'hFC;
    localparam logic [7:0]  SUBTYPE_DEAUTH   = 8'hC0;
    localparam logic [7:0]  SUBTYPE_DISASSOC = 8'hA0;

    localparam logic [15:0] WINDOW_TICKS_RST     = 16'd700;
    localparam logic [15:0] HOP_TICKS_RST        = 16'd800;
    localparam logic [15:0] DEAUTH_THRESHOLD_RST = 16'd8;
    localparam logic [7:0]  RATIO_FACTOR_RST     = 8'd10;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [CHAN_WIDTH-1:0]  LAST_CHANNEL = CHAN_WIDTH'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        REG_WINDOW_TICKS     = 2'd0,
        REG_HOP_TICKS        = 2'd1,
        REG_DEAUTH_THRESHOLD = 2'd2,
        REG_RATIO_FACTOR     = 2'd3
    } reg_index_t;

    typedef enum logic {
        ACT_FRAME = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef struct packed {
        logic [15:0] window_ticks;
        logic [15:0] hop_ticks;
        logic [15:0] deauth_threshold;
        logic [7:0]  ratio_factor;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [11:0] frame_length;
        logic [7:0]  frame_control;
    } item_t;

    typedef struct packed {
        logic                  attack_active;
        logic [15:0]           packet_count;
        logic [15:0]           deauth_count;
        logic [CHAN_WIDTH-1:0] channel_number;
        logic                  window_closed;
    } result_t;

    // management deauthentication or disassociation subtype
    function automatic logic is_deauth_like(input logic [7:0] fc);
        logic [7:0] sub;
        sub = fc & SUBTYPE_MASK;
        return (fc >= MGMT_MIN) && ((sub == SUBTYPE_DEAUTH) || (sub == SUBTYPE_DISASSOC));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // clamp a counter to the 16-bit output field
    function automatic logic [15:0] to_out16(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// ===== hdl/dfwd_regs.sv =====
// ----------------------------------------------------------------------------
// dfwd_regs
// apb-style configuration register file for window, hop, threshold and ratio
// ----------------------------------------------------------------------------
module dfwd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dfwd_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [dfwd_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [dfwd_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output dfwd_pkg::cfg_t                   cfg
);

    dfwd_pkg::cfg_t       cfg_reg;
    dfwd_pkg::cfg_t       cfg_next;
    dfwd_pkg::reg_index_t sel_index;
    logic                 wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign sel_index = dfwd_pkg::reg_index_t'(paddr[dfwd_pkg::ADDR_WIDTH-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel_index)
                dfwd_pkg::REG_WINDOW_TICKS:     cfg_next.window_ticks     = pwdata[15:0];
                dfwd_pkg::REG_HOP_TICKS:        cfg_next.hop_ticks        = pwdata[15:0];
                dfwd_pkg::REG_DEAUTH_THRESHOLD: cfg_next.deauth_threshold = pwdata[15:0];
                dfwd_pkg::REG_RATIO_FACTOR:     cfg_next.ratio_factor     = pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (sel_index)
            dfwd_pkg::REG_WINDOW_TICKS:     prdata = 32'(cfg_reg.window_ticks);
            dfwd_pkg::REG_HOP_TICKS:        prdata = 32'(cfg_reg.hop_ticks);
            dfwd_pkg::REG_DEAUTH_THRESHOLD: prdata = 32'(cfg_reg.deauth_threshold);
            dfwd_pkg::REG_RATIO_FACTOR:     prdata = 32'(cfg_reg.ratio_factor);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks     <= dfwd_pkg::WINDOW_TICKS_RST;
            cfg_reg.hop_ticks        <= dfwd_pkg::HOP_TICKS_RST;
            cfg_reg.deauth_threshold <= dfwd_pkg::DEAUTH_THRESHOLD_RST;
            cfg_reg.ratio_factor     <= dfwd_pkg::RATIO_FACTOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/dfwd_core.sv =====
// ----------------------------------------------------------------------------
// dfwd_core
// window and hop state with the single-pass per-item update and decision
// ----------------------------------------------------------------------------
module dfwd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  dfwd_pkg::cfg_t    cfg,
    input  logic              step,
    input  dfwd_pkg::item_t   item,
    output dfwd_pkg::result_t result
);

    localparam int PROD_WIDTH = dfwd_pkg::COUNT_WIDTH + 8;

    logic [dfwd_pkg::COUNT_WIDTH-1:0] packet_reg, packet_next;
    logic [dfwd_pkg::COUNT_WIDTH-1:0] deauth_reg, deauth_next;
    logic [15:0]                      window_reg, window_next;
    logic [15:0]                      hop_reg, hop_next;
    logic [dfwd_pkg::CHAN_WIDTH-1:0]  chan_reg, chan_next;
    logic                             flag_reg, flag_next;

    logic [15:0]                      wlen, hlen;
    logic [16:0]                      window_inc, hop_inc;
    logic [PROD_WIDTH-1:0]            ratio_prod;
    logic                             thresh_hit, ratio_hit;
    logic [dfwd_pkg::COUNT_WIDTH-1:0] shown_pk, shown_da;
    logic                             closed;

    assign wlen = (cfg.window_ticks == 16'd0) ? 16'd1 : cfg.window_ticks;
    assign hlen = (cfg.hop_ticks == 16'd0) ? 16'd1 : cfg.hop_ticks;
    assign window_inc = 17'(window_reg) + 17'd1;
    assign hop_inc    = 17'(hop_reg) + 17'd1;

    assign ratio_prod = PROD_WIDTH'(deauth_reg) * PROD_WIDTH'(cfg.ratio_factor);
    assign thresh_hit = 32'(deauth_reg) >= 32'(cfg.deauth_threshold);
    assign ratio_hit  = (packet_reg != '0) && (ratio_prod >= PROD_WIDTH'(packet_reg));

    always_comb
    begin
        packet_next = packet_reg;
        deauth_next = deauth_reg;
        window_next = window_reg;
        hop_next    = hop_reg;
        chan_next   = chan_reg;
        flag_next   = flag_reg;
        closed      = 1'b0;

        unique case (dfwd_pkg::action_t'(item.action))
            dfwd_pkg::ACT_FRAME:
            begin
                if (item.frame_length >= dfwd_pkg::MIN_FRAME_LEN)
                begin
                    packet_next = dfwd_pkg::sat_inc(packet_reg);
                    if (dfwd_pkg::is_deauth_like(item.frame_control))
                    begin
                        deauth_next = dfwd_pkg::sat_inc(deauth_reg);
                    end
                end
                shown_pk = packet_next;
                shown_da = deauth_next;
            end
            dfwd_pkg::ACT_TICK:
            begin
                // channel hop first
                if (hop_inc >= 17'(hlen))
                begin
                    hop_next  = '0;
                    chan_next = (chan_reg >= dfwd_pkg::LAST_CHANNEL)
                                ? '0 : chan_reg + dfwd_pkg::CHAN_WIDTH'(1);
                end
                else
                begin
                    hop_next = hop_inc[15:0];
                end

                shown_pk = packet_reg;
                shown_da = deauth_reg;
                if (window_inc >= 17'(wlen))
                begin
                    flag_next   = thresh_hit || ratio_hit;
                    packet_next = '0;
                    deauth_next = '0;
                    window_next = '0;
                    closed      = 1'b1;
                end
                else
                begin
                    window_next = window_inc[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_reg <= '0;
            deauth_reg <= '0;
            window_reg <= '0;
            hop_reg    <= '0;
            chan_reg   <= '0;
            flag_reg   <= 1'b0;
        end
        else if (step)
        begin
            packet_reg <= packet_next;
            deauth_reg <= deauth_next;
            window_reg <= window_next;
            hop_reg    <= hop_next;
            chan_reg   <= chan_next;
            flag_reg   <= flag_next;
        end
    end

    always_comb
    begin
        result.attack_active  = flag_next;
        result.packet_count   = dfwd_pkg::to_out16(shown_pk);
        result.deauth_count   = dfwd_pkg::to_out16(shown_da);
        result.channel_number = chan_next + dfwd_pkg::CHAN_WIDTH'(1);
        result.window_closed  = closed;
    end

endmodule

// ===== hdl/deauth_flood_window_detector.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_window_detector
// counts frames and deauth/disassoc frames per tick window, flags floods
// ----------------------------------------------------------------------------
//
//  channel   signals                                         direction
//  item      item_valid/item_ready, action, frame_length,    in
//            frame_control
//  result    result_valid/result_ready, attack_active,       out
//            packet_count, deauth_count, channel_number,
//            window_closed
//  config    psel, penable, pwrite, paddr, pwdata, prdata,   in/out
//            pready
//
//  one transfer per cycle sustained while result_ready is high; a taken item
//  passes through the input register, then one evaluation pass into the
//  result register, which drives the result channel
//  the evaluation pass is bounded by the 16x8 ratio multiply and compare
//  rst_n clears counters, timers, channel index, flag and both valid bits;
//  configuration returns to its reset values
//  while result_ready is low the result register holds and one further item
//  waits in the input register
//
module deauth_flood_window_detector (
    input  logic                                clk,
    input  logic                                rst_n,

    // item channel
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                action,
    input  logic [11:0]                         frame_length,
    input  logic [7:0]                          frame_control,

    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                attack_active,
    output logic [15:0]                         packet_count,
    output logic [15:0]                         deauth_count,
    output logic [dfwd_pkg::CHAN_WIDTH-1:0]     channel_number,
    output logic                                window_closed,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dfwd_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [dfwd_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [dfwd_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                pready
);

    dfwd_pkg::cfg_t    cfg;
    dfwd_pkg::item_t   item_reg;
    dfwd_pkg::result_t eval_result;
    dfwd_pkg::result_t result_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              item_take;
    logic              advance;

    // item moves from input register into result register when the
    // result register is empty or being drained this cycle
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    assign in_valid_next  = item_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result_ready);

    dfwd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state updates only when the held item is evaluated
    dfwd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item_reg),
        .result (eval_result)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.action        <= action;
            item_reg.frame_length  <= frame_length;
            item_reg.frame_control <= frame_control;
        end
        if (advance)
        begin
            result_reg <= eval_result;
        end
    end

    assign result_valid   = out_valid_reg;
    assign attack_active  = result_reg.attack_active;
    assign packet_count   = result_reg.packet_count;
    assign deauth_count   = result_reg.deauth_count;
    assign channel_number = result_reg.channel_number;
    assign window_closed  = result_reg.window_closed;

endmodule

// ===== test/deauth_flood_window_detector_test.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_window_detector_test
// self-checking bench for the deauth flood window detector: a local model of
// the counters, timers and decision predicts every result, which is checked
// field by field against the result channel under random sender gaps and
// receiver stalls, across several register settings
// ----------------------------------------------------------------------------
module deauth_flood_window_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_TICKS = 4;     // quiet time after the last report has come back
    localparam int MAX_PRINTS   = 40;
    localparam int PHASE_ITEMS  = 210;
    localparam int LONG_ITEMS   = 260;

    // clock, reset and block ports
    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            item_valid    = 1'b0;
    logic                            item_ready;
    logic                            action        = 1'b0;
    logic [11:0]                     frame_length  = '0;
    logic [7:0]                      frame_control = '0;
    logic                            result_valid;
    logic                            result_ready  = 1'b0;
    logic                            attack_active;
    logic [15:0]                     packet_count;
    logic [15:0]                     deauth_count;
    logic [dfwd_pkg::CHAN_WIDTH-1:0] channel_number;
    logic                            window_closed;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [dfwd_pkg::ADDR_WIDTH-1:0] paddr         = '0;
    logic [dfwd_pkg::DATA_WIDTH-1:0] pwdata        = '0;
    logic [dfwd_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;

    // local copy of the detector state and its settings
    dfwd_pkg::cfg_t det_cfg = '{dfwd_pkg::WINDOW_TICKS_RST, dfwd_pkg::HOP_TICKS_RST,
                                dfwd_pkg::DEAUTH_THRESHOLD_RST,
                                dfwd_pkg::RATIO_FACTOR_RST};
    logic [dfwd_pkg::COUNT_WIDTH-1:0] frames_seen   = '0;
    logic [dfwd_pkg::COUNT_WIDTH-1:0] deauths_seen  = '0;
    int                               win_age       = 0;
    int                               hop_age       = 0;
    int                               chan_idx      = 0;
    logic                             flood_latched = 1'b0;

    // reports still owed by the block, oldest first
    dfwd_pkg::result_t due_reports[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int ready_run   = 0;

    deauth_flood_window_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .action         (action),
        .frame_length   (frame_length),
        .frame_control  (frame_control),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .attack_active  (attack_active),
        .packet_count   (packet_count),
        .deauth_count   (deauth_count),
        .channel_number (channel_number),
        .window_closed  (window_closed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("deauth_flood_window_detector: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR @%0t %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // detector model: applies one accepted event and queues its report
    // ------------------------------------------------------------------
    function automatic void advance_detector(input dfwd_pkg::item_t ev);
        dfwd_pkg::result_t rep;
        logic [7:0]        subtype;
        logic [31:0]       weighted;
        int                hop_len;
        int                win_len;
        rep = '0;
        if (dfwd_pkg::action_t'(ev.action) == dfwd_pkg::ACT_FRAME)
        begin
            // runt frames leave everything untouched
            if (ev.frame_length >= dfwd_pkg::MIN_FRAME_LEN)
            begin
                if (frames_seen != dfwd_pkg::COUNT_MAX)
                    frames_seen = frames_seen + 1'b1;
                subtype = ev.frame_control & dfwd_pkg::SUBTYPE_MASK;
                if (ev.frame_control >= dfwd_pkg::MGMT_MIN &&
                    (subtype == dfwd_pkg::SUBTYPE_DEAUTH ||
                     subtype == dfwd_pkg::SUBTYPE_DISASSOC) &&
                    deauths_seen != dfwd_pkg::COUNT_MAX)
                    deauths_seen = deauths_seen + 1'b1;
            end
            rep.packet_count = frames_seen;
            rep.deauth_count = deauths_seen;
        end
        else
        begin
            // a zero length behaves as one
            hop_len = (det_cfg.hop_ticks == 0) ? 1 : int'(det_cfg.hop_ticks);
            win_len = (det_cfg.window_ticks == 0) ? 1 : int'(det_cfg.window_ticks);
            // channel hop comes before the window decision
            hop_age++;
            if (hop_age >= hop_len)
            begin
                hop_age  = 0;
                chan_idx = (chan_idx + 1 >= dfwd_pkg::NUM_CHANNELS) ? 0 : chan_idx + 1;
            end
            win_age++;
            rep.packet_count = frames_seen;
            rep.deauth_count = deauths_seen;
            if (win_age >= win_len)
            begin
                weighted = 32'(deauths_seen) * 32'(det_cfg.ratio_factor);
                flood_latched = (deauths_seen >= det_cfg.deauth_threshold) ||
                                (frames_seen != 0 && weighted >= 32'(frames_seen));
                frames_seen       = '0;
                deauths_seen      = '0;
                win_age           = 0;
                rep.window_closed = 1'b1;
            end
        end
        rep.attack_active  = flood_latched;
        rep.channel_number = dfwd_pkg::CHAN_WIDTH'(chan_idx + 1);
        due_reports.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dfwd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_reports.size() == 0)
                report_mismatch("result with nothing outstanding", packet_count, 0);
            else
            begin
                want = due_reports.pop_front();
                if (attack_active !== want.attack_active)
                    report_mismatch("attack_active", attack_active, want.attack_active);
                if (packet_count !== want.packet_count)
                    report_mismatch("packet_count", packet_count, want.packet_count);
                if (deauth_count !== want.deauth_count)
                    report_mismatch("deauth_count", deauth_count, want.deauth_count);
                if (channel_number !== want.channel_number)
                    report_mismatch("channel_number", channel_number,
                                    want.channel_number);
                if (window_closed !== want.window_closed)
                    report_mismatch("window_closed", window_closed, want.window_closed);
            end
        end
        // ready runs: long open stretches, short stalls, short open bursts
        if (ready_run > 0)
            ready_run--;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    result_ready <= 1'b1;
                    ready_run = $urandom_range(30, 120);
                end
                2, 3, 4, 5:
                begin
                    result_ready <= 1'b0;
                    ready_run = $urandom_range(1, 4);
                end
                default:
                begin
                    result_ready <= 1'b1;
                    ready_run = $urandom_range(1, 10);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // item channel: one transfer, then possibly an idle gap
    // ------------------------------------------------------------------
    task automatic send_event(input dfwd_pkg::item_t ev);
        item_valid    <= 1'b1;
        action        <= ev.action;
        frame_length  <= ev.frame_length;
        frame_control <= ev.frame_control;
        do
            @(posedge clk);
        while (!item_ready);
        advance_detector(ev);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // mostly short bursts, now and then a long unbroken one
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            if ($urandom_range(0, 4) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // stop sending and wait for every outstanding report, then let it settle
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    function automatic logic [dfwd_pkg::ADDR_WIDTH-1:0] reg_addr(
        input dfwd_pkg::reg_index_t idx);
        return dfwd_pkg::ADDR_WIDTH'(int'(idx) * 4);
    endfunction

    task automatic check_register(input dfwd_pkg::reg_index_t idx,
                                  input logic [15:0] value);
        logic [dfwd_pkg::DATA_WIDTH-1:0] mask;
        logic [dfwd_pkg::DATA_WIDTH-1:0] readback;
        mask = (idx == dfwd_pkg::REG_RATIO_FACTOR) ? 32'h0000_00FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((readback & mask) !== (dfwd_pkg::DATA_WIDTH'(value) & mask))
            report_mismatch($sformatf("register %s readback", idx.name()),
                            readback & mask, dfwd_pkg::DATA_WIDTH'(value) & mask);
    endtask

    task automatic write_register(input dfwd_pkg::reg_index_t idx,
                                  input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= dfwd_pkg::DATA_WIDTH'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dfwd_pkg::REG_WINDOW_TICKS:     det_cfg.window_ticks     = value;
            dfwd_pkg::REG_HOP_TICKS:        det_cfg.hop_ticks        = value;
            dfwd_pkg::REG_DEAUTH_THRESHOLD: det_cfg.deauth_threshold = value;
            dfwd_pkg::REG_RATIO_FACTOR:     det_cfg.ratio_factor     = value[7:0];
            default:;
        endcase
        @(posedge clk);
        check_register(idx, value);
    endtask

    // registers change only once the block has gone quiet
    task automatic configure_detector(input logic [15:0] win, input logic [15:0] hop,
                                      input logic [15:0] thr, input logic [7:0] ratio);
        hold_until_drained();
        write_register(dfwd_pkg::REG_WINDOW_TICKS, win);
        write_register(dfwd_pkg::REG_HOP_TICKS, hop);
        write_register(dfwd_pkg::REG_DEAUTH_THRESHOLD, thr);
        write_register(dfwd_pkg::REG_RATIO_FACTOR, 16'(ratio));
    endtask

    function automatic dfwd_pkg::item_t frame_event(input logic [11:0] len,
                                                    input logic [7:0] fc);
        return '{dfwd_pkg::ACT_FRAME, len, fc};
    endfunction

    function automatic dfwd_pkg::item_t tick_event();
        return '{dfwd_pkg::ACT_TICK, 12'($urandom_range(0, 4095)),
                 8'($urandom_range(0, 255))};
    endfunction

    // random event with a given share of ticks and of deauth-like frames
    function automatic dfwd_pkg::item_t random_event(input int tick_pct,
                                                     input int deauth_pct);
        dfwd_pkg::item_t ev;
        int              pick;
        ev.action = ($urandom_range(1, 100) <= tick_pct) ? dfwd_pkg::ACT_TICK
                                                          : dfwd_pkg::ACT_FRAME;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            ev.frame_length = 12'($urandom_range(0, 23));
        else if (pick == 1)
            ev.frame_length = 12'($urandom_range(0, 4095));
        else
            ev.frame_length = 12'($urandom_range(24, 1600));
        if ($urandom_range(1, 100) <= deauth_pct)
            ev.frame_control = ($urandom_range(0, 1) ? dfwd_pkg::SUBTYPE_DEAUTH
                                                     : dfwd_pkg::SUBTYPE_DISASSOC) |
                               8'($urandom_range(0, 3));
        else
            ev.frame_control = 8'($urandom_range(0, 255));
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // settings come out of reset at their documented values
    task automatic test_register_defaults();
        check_register(dfwd_pkg::REG_WINDOW_TICKS, dfwd_pkg::WINDOW_TICKS_RST);
        check_register(dfwd_pkg::REG_HOP_TICKS, dfwd_pkg::HOP_TICKS_RST);
        check_register(dfwd_pkg::REG_DEAUTH_THRESHOLD, dfwd_pkg::DEAUTH_THRESHOLD_RST);
        check_register(dfwd_pkg::REG_RATIO_FACTOR, 16'(dfwd_pkg::RATIO_FACTOR_RST));
    endtask

    // length filter and subtype decoding at the reset settings
    task automatic test_frame_filtering();
        send_event(frame_event(12'd0, dfwd_pkg::SUBTYPE_DEAUTH));     // runt, ignored
        send_event(frame_event(12'd23, dfwd_pkg::SUBTYPE_DISASSOC));  // runt, ignored
        send_event(frame_event(dfwd_pkg::MIN_FRAME_LEN, 8'h00));
        send_event(frame_event(12'hFFF, 8'hFF));
        send_event(frame_event(dfwd_pkg::MIN_FRAME_LEN, dfwd_pkg::SUBTYPE_DEAUTH));
        send_event(frame_event(12'd100, 8'hC3));
        send_event(frame_event(12'd200, dfwd_pkg::SUBTYPE_DISASSOC));
        send_event(frame_event(12'd300, 8'hA3));
        send_event(frame_event(12'd64, 8'hC4));
        send_event(frame_event(12'd64, 8'h7F));
    endtask

    // window close, ratio test, hop ordering and the zero-length settings
    task automatic test_tick_rules();
        // one deauth in two packets fails a ratio of one
        configure_detector(16'd3, 16'd2, 16'hFFFF, 8'd1);
        send_event(frame_event(12'd100, dfwd_pkg::SUBTYPE_DEAUTH));
        send_event(frame_event(12'd60, 8'h08));
        send_event(tick_event());
        send_event(tick_event());
        send_event(tick_event());
        // zero window and hop act as one, zero threshold always trips
        configure_detector(16'd0, 16'd0, 16'd0, 8'd0);
        send_event(tick_event());
        send_event(frame_event(12'd40, dfwd_pkg::SUBTYPE_DEAUTH));
        send_event(tick_event());
        // zero ratio never trips, so only the threshold decides
        configure_detector(16'd1, 16'd1, 16'd2, 8'd0);
        send_event(frame_event(12'd40, dfwd_pkg::SUBTYPE_DISASSOC));
        send_event(frame_event(12'd40, dfwd_pkg::SUBTYPE_DISASSOC));
        send_event(tick_event());
        send_event(frame_event(12'd40, 8'hA1));
        send_event(tick_event());
        // widest ratio: one deauth covers many packets
        configure_detector(16'd2, 16'hFFFF, 16'hFFFF, 8'd255);
        send_event(frame_event(12'd40, 8'h00));
        send_event(frame_event(12'd40, 8'hC2));
        send_event(tick_event());
        send_event(tick_event());
    endtask

    // many frames build up inside one long window, then a short window closes it
    task automatic test_long_window();
        configure_detector(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        for (int n = 0; n < LONG_ITEMS; n++)
            send_event(random_event(0, 50));
        // shorten the window so the next tick closes it at full count
        configure_detector(16'd1, 16'hFFFF, 16'hFFFF, 8'd255);
        send_event(tick_event());
        send_event(frame_event(12'd24, dfwd_pkg::SUBTYPE_DEAUTH));
    endtask

    // random traffic over minimum, maximum and random settings
    task automatic test_random_traffic();
        int tick_pct;
        int deauth_pct;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                configure_detector(16'd1, 16'd1, 16'd1, 8'd1);
            else if (phase == 1)
                configure_detector(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
            else
                configure_detector(16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)),
                                   16'($urandom_range(1, 40)),
                                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                               : 8'($urandom_range(1, 5)));
            tick_pct   = $urandom_range(10, 50);
            deauth_pct = $urandom_range(5, 60);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase pause until everything outstanding has come back
                if (n == PHASE_ITEMS / 2)
                    hold_until_drained();
                send_event(random_event(tick_pct, deauth_pct));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_defaults();
        test_frame_filtering();
        test_tick_rules();
        test_long_window();
        test_random_traffic();
        hold_until_drained();
        if (mismatches == 0)
            $display("deauth_flood_window_detector: match");
        else
            $display("deauth_flood_window_detector: mismatch");
        $finish;
    end

endmodule

// ===== deauth_flood_window_detector.f =====
hdl/dfwd_pkg.sv
hdl/dfwd_regs.sv
hdl/dfwd_core.sv
hdl/deauth_flood_window_detector.sv
test/deauth_flood_window_detector_test.sv
